@@ hdl/llc_fcs_crc24_macros.svh @@
// Assertion macros shared by the frame check sequence RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef LLC_FCS_CRC24_MACROS_SVH
`define LLC_FCS_CRC24_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LFC24_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LFC24_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lfc24_pkg.sv @@
// Types, constants and the byte-wide CRC update for the frame check sequence block.
// No dependencies; the interfaces, the RTL and the testbench import this package.
`default_nettype none

package lfc24_pkg;

   localparam int unsigned CRC_W   = 24;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 9;

   localparam logic [CRC_W-1:0]   FCS_POLY       = 24'hAD85DD;
   localparam logic [CRC_W-1:0]   FCS_PRESET     = 24'hFFFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 9'd511;
   localparam logic [COUNT_W-1:0] HDR_CTRL_IDX   = 9'd1;
   localparam logic [COUNT_W-1:0] HDR_SAPI_IDX   = 9'd2;
   localparam logic [9:0]         HEADER_OCTETS  = 10'd3;
   localparam logic [2:0]         UI_FRAME_CODE  = 3'b110;
   localparam logic [BYTE_W-1:0]  INFO_LEN_RESET = 8'd4;

   // One input beat as it moves from the input register to the engine.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } beat_type;

   // Reflected CRC, one octet: eight shift steps on a 24-bit value.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] octet);
      logic [CRC_W-1:0] r;
      r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, octet};
      for (int k = 0; k < BYTE_W; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ FCS_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // Complement, then exchange the outer bytes of the register.
   function automatic logic [CRC_W-1:0] fcs_format(input logic [CRC_W-1:0] crc);
      logic [CRC_W-1:0] r;
      r = ~crc;
      return {r[7:0], r[15:8], r[23:16]};
   endfunction

endpackage

`default_nettype wire

@@ hdl/lfc24_intf.sv @@
// Valid/ready channel interfaces: input octets, check value results and register writes.
// Depends on lfc24_pkg for field widths.
`default_nettype none

interface lfc24_req_if import lfc24_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lfc24_rsp_if import lfc24_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CRC_W-1:0] fcs;
   modport source (output valid, output fcs, input ready);
   modport sink   (input valid, input fcs, output ready);
endinterface

interface lfc24_csr_if import lfc24_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] unprotected_info_len;
   modport source (output valid, output unprotected_info_len, input ready);
   modport sink   (input valid, input unprotected_info_len, output ready);
endinterface

`default_nettype wire

@@ hdl/lfc24_fcs_engine.sv @@
// CRC register, octet counter and UI coverage flags; one octet per enabled cycle.
// Depends on lfc24_pkg and the assertion macros header.
`default_nettype none
`include "llc_fcs_crc24_macros.svh"

module lfc24_fcs_engine import lfc24_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire beat_type          beat,
   input  wire logic [BYTE_W-1:0] info_len,
   output      logic [CRC_W-1:0]  fcs_next
);

   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ui_ff, ui_in;
   logic               limited_ff, limited_in;
   logic               covered;
   logic [CRC_W-1:0]   crc_upd;

   always_comb begin
      ui_in      = ui_ff | ((count_ff == HDR_CTRL_IDX) &&
                            (beat.data_byte[7:5] == UI_FRAME_CODE));
      limited_in = limited_ff | ((count_ff == HDR_SAPI_IDX) && ui_in &&
                                 !beat.data_byte[0]);
      covered    = !limited_in ||
                   ({1'b0, count_ff} < ({2'b00, info_len} + HEADER_OCTETS));
      crc_upd    = crc_byte(crc_ff, beat.data_byte);
      crc_in     = covered ? crc_upd : crc_ff;
      count_in   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      fcs_next   = fcs_format(crc_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= FCS_PRESET;
         count_ff   <= '0;
         ui_ff      <= 1'b0;
         limited_ff <= 1'b0;
      end else if (step_en) begin
         if (beat.last_byte) begin
            crc_ff     <= FCS_PRESET;
            count_ff   <= '0;
            ui_ff      <= 1'b0;
            limited_ff <= 1'b0;
         end else begin
            crc_ff     <= crc_in;
            count_ff   <= count_in;
            ui_ff      <= ui_in;
            limited_ff <= limited_in;
         end
      end
   end

   `LFC24_ASSERT_NEXT(a_preset_after_last, clock, reset, step_en && beat.last_byte,
      (count_ff == '0) && (crc_ff == FCS_PRESET) && !limited_ff, "frame state not preset")
   `LFC24_ASSERT_NEXT(a_count_advances, clock, reset,
      step_en && !beat.last_byte && (count_ff != COUNT_MAX),
      count_ff == $past(count_ff) + 1'b1, "octet count did not advance")
   `LFC24_ASSERT_NOW(a_limit_needs_ui, clock, reset, limited_ff, ui_ff,
      "coverage limited without a UI frame")

endmodule

`default_nettype wire

@@ hdl/llc_fcs_crc24.sv @@
// Order: an octet is registered in the input register on acceptance; its CRC step runs
// as it moves on into the engine, and a last octet then also loads the result register.
// Throughput: one octet per clock, limited only by the byte-wide CRC step between the
// input and CRC registers, except that a held last octet waits while a result is unread.
// Reset (synchronous, active high): CRC preset to all ones, counters and flags cleared,
// unprotected_info_len set to 4, both pipeline registers empty.
// Depends on lfc24_pkg, lfc24_intf, lfc24_fcs_engine and the assertion macros header.
`default_nettype none
`include "llc_fcs_crc24_macros.svh"

module llc_fcs_crc24 import lfc24_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   lfc24_req_if.sink   req_bus,
   lfc24_rsp_if.source rsp_bus,
   lfc24_csr_if.sink   csr_bus
);

   // The input register holds one beat. It moves on into the engine whenever the beat
   // causes no result, or whenever the result register is empty or being emptied, so
   // a new beat can be taken in every cycle except while a last beat waits behind a result.
   logic              in_valid_ff;
   beat_type          in_beat_ff;
   logic              advance;

   logic              out_valid_ff;
   logic [CRC_W-1:0]  out_fcs_ff;

   logic [BYTE_W-1:0] info_len_ff;
   logic [CRC_W-1:0]  fcs_next;

   assign advance = in_valid_ff &&
                    (!in_beat_ff.last_byte || !out_valid_ff || rsp_bus.ready);

   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.fcs   = out_fcs_ff;

   // The register must be written only while the block is idle, so that each octet sees
   // the value in force when it was accepted; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         info_len_ff <= INFO_LEN_RESET;
      end else if (csr_bus.valid) begin
         info_len_ff <= csr_bus.unprotected_info_len;
      end
   end

   // Input register: the payload needs no reset, only the valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_beat_ff.data_byte <= req_bus.data_byte;
         in_beat_ff.last_byte <= req_bus.last_byte;
      end
   end

   lfc24_fcs_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .beat     (in_beat_ff),
      .info_len (info_len_ff),
      .fcs_next (fcs_next)
   );

   // Result register: loaded when a last beat passes through the engine.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_beat_ff.last_byte) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && in_beat_ff.last_byte) begin
         out_fcs_ff <= fcs_next;
      end
   end

   // A result is always produced after a last beat has passed through the engine.
   `LFC24_ASSERT_NEXT(a_last_gives_result, clock, reset, advance && in_beat_ff.last_byte,
      out_valid_ff, "no result after last beat")
   // A waiting result is never overwritten by the next frame's check value.
   `LFC24_ASSERT_NOW(a_no_overwrite, clock, reset,
      out_valid_ff && !rsp_bus.ready && in_beat_ff.last_byte, !advance,
      "pending result overwritten")
   // An accepted beat always lands in the input register.
   `LFC24_ASSERT_NEXT(a_accept_fills, clock, reset, req_bus.valid && req_bus.ready,
      in_valid_ff, "accepted beat lost")

endmodule

`default_nettype wire

@@ dv/llc_fcs_crc24_test.sv @@
// Self-checking testbench for the LLC frame check sequence block (24-bit reflected CRC).
// Depends on lfc24_pkg, the channel interfaces in lfc24_intf and the llc_fcs_crc24 RTL.
`timescale 1ns / 1ps

module llc_fcs_crc24_test;
   import lfc24_pkg::*;

   // Kinds of frame that the stimulus builds. Unprotected UI frames are the
   // ones whose coverage is cut short by the register.
   typedef enum int {
      FRAME_UI_UNPROT,
      FRAME_UI_PROT,
      FRAME_OTHER,
      FRAME_NOISE
   } frame_kind_type;

   localparam int FILL_RANDOM = -1;
   localparam int SETTLE_CYCLES = 4;

   logic clock;
   logic reset;

   lfc24_req_if req_ch ();
   lfc24_rsp_if rsp_ch ();
   lfc24_csr_if csr_ch ();

   llc_fcs_crc24 dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   // Independent copy of the block's frame state and of its one register.
   logic [CRC_W-1:0]   crc_acc;
   logic [COUNT_W-1:0] octet_idx;
   bit                 ui_seen;
   bit                 cover_cut;
   logic [BYTE_W-1:0]  info_len;

   // Check values still owed by the block, oldest first.
   logic [CRC_W-1:0] fcs_owed_q[$];

   int errors;
   int frames_sent;
   int octets_sent;
   int fcs_checked;
   int info_len_writes;
   int sender_burst_left;
   bit sender_steady;
   bit receiver_steady;

   // Clock with an 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Safety net: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // One byte-wide step of the reflected CRC, worked one input bit at a time:
   // each bit is folded into the low end before the register shifts right.
   function automatic logic [CRC_W-1:0] fold_octet(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] octet);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = acc;
      for (int k = 0; k < BYTE_W; k++) begin
         fb = r[0] ^ octet[k];
         r  = {1'b0, r[CRC_W-1:1]};
         if (fb) begin
            r = r ^ 24'hAD85DD;
         end
      end
      return r;
   endfunction

   // Clears the per-frame state, as the block does after every last octet.
   function automatic void preset_frame();
      crc_acc   = 24'hFFFFFF;
      octet_idx = '0;
      ui_seen   = 1'b0;
      cover_cut = 1'b0;
   endfunction

   // Steps the frame state by one accepted octet. On the last octet the check
   // value is complemented, its outer bytes are exchanged, and it is queued.
   function automatic void predict_octet(input beat_type b);
      logic [CRC_W-1:0] inv;
      int               limit;
      if (octet_idx == 9'd1 && b.data_byte[7:5] == UI_FRAME_CODE) begin
         ui_seen = 1'b1;
      end
      if (octet_idx == 9'd2 && ui_seen && !b.data_byte[0]) begin
         cover_cut = 1'b1;
      end
      limit = 3 + int'(info_len);
      if (!cover_cut || int'(octet_idx) < limit) begin
         crc_acc = fold_octet(crc_acc, b.data_byte);
      end
      if (octet_idx != 9'd511) begin
         octet_idx = octet_idx + 9'd1;
      end
      if (b.last_byte) begin
         inv = crc_acc ^ 24'hFFFFFF;
         fcs_owed_q.push_back({inv[7:0], inv[15:8], inv[23:16]});
         preset_frame();
      end
   endfunction

   // Beat monitor. The result beat is checked before the input beat of the
   // same edge is predicted, although the input and result registers keep them apart.
   always @(posedge clock) begin
      beat_type seen;
      logic [CRC_W-1:0] owed;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (fcs_owed_q.size() == 0) begin
               $error("fcs beat with nothing owed: actual %06h", rsp_ch.fcs);
               errors++;
            end else begin
               owed = fcs_owed_q.pop_front();
               fcs_checked++;
               if (rsp_ch.fcs !== owed) begin
                  $error("fcs mismatch: expected %06h, actual %06h", owed, rsp_ch.fcs);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.data_byte = req_ch.data_byte;
            seen.last_byte = req_ch.last_byte;
            predict_octet(seen);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            info_len = csr_ch.unprotected_info_len;
         end
      end
   end

   // Receiver: ready follows the bits of a random 16-bit pattern in turn; a new pattern
   // is drawn once all are used, with steady stretches of constant readiness in between.
   initial begin
      logic [15:0] pattern;
      int          pos;
      rsp_ch.ready    = 1'b0;
      receiver_steady = 1'b0;
      pattern         = 16'h0;
      pos             = 0;
      forever begin
         @(negedge clock);
         if (pos == 0) begin
            pattern = 16'($urandom);
            if ($urandom_range(0, 5) == 0) begin
               receiver_steady = !receiver_steady;
            end
         end
         rsp_ch.ready <= receiver_steady ? 1'b1 : pattern[pos];
         pos = (pos + 1) % 16;
      end
   end

   // Presents one beat from a falling edge and holds it until it is taken.
   // Returns at the falling edge after acceptance with valid still high.
   task automatic send_beat(input beat_type b);
      req_ch.data_byte <= b.data_byte;
      req_ch.last_byte <= b.last_byte;
      req_ch.valid     <= 1'b1;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
      @(negedge clock);
      octets_sent++;
   endtask

   // Sender pacing: bursts of random length separated by random gaps, except
   // in steady stretches where beats follow back to back.
   task automatic pace_sender();
      int gap;
      if (sender_steady) return;
      if (sender_burst_left > 0) begin
         sender_burst_left--;
         return;
      end
      gap = $urandom_range(1, 7);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clock);
      sender_burst_left = $urandom_range(0, 15);
   endtask

   // Stops the sender until every owed check value has arrived, then lets the
   // pipeline empty of octets that owe nothing.
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (fcs_owed_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; only ever called with the block settled.
   task automatic write_info_len(input logic [BYTE_W-1:0] value);
      csr_ch.unprotected_info_len <= value;
      csr_ch.valid                <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_ch.ready) break;
      end
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      info_len_writes++;
   endtask

   // Sends octets first .. first+count-1 of a frame of total length len. The
   // control and SAPI octets are shaped by kind; fill gives a fixed value for
   // the other octets, or random content.
   task automatic send_octets(input frame_kind_type kind, input int len, input int first,
                              input int count, input int fill);
      beat_type b;
      for (int i = first; i < first + count; i++) begin
         b.data_byte = (fill == FILL_RANDOM) ? 8'($urandom_range(0, 255)) : 8'(fill);
         if (i == 1) begin
            if (kind == FRAME_UI_UNPROT || kind == FRAME_UI_PROT) begin
               b.data_byte[7:5] = UI_FRAME_CODE;
            end else if (kind == FRAME_OTHER && b.data_byte[7:5] == UI_FRAME_CODE) begin
               b.data_byte[5] = 1'b1;
            end
         end
         if (i == 2 && kind == FRAME_UI_UNPROT) b.data_byte[0] = 1'b0;
         if (i == 2 && kind == FRAME_UI_PROT) b.data_byte[0] = 1'b1;
         b.last_byte = (i == len - 1);
         send_beat(b);
         pace_sender();
      end
      if (first + count == len) frames_sent++;
   endtask

   task automatic send_frame(input frame_kind_type kind, input int len, input int fill);
      send_octets(kind, len, 0, len, fill);
   endtask

   // With the reset length of four, an unprotected UI frame is covered up to
   // octet six; protected UI and other frames are covered whole.
   task automatic test_reset_length();
      send_frame(FRAME_UI_UNPROT, 9, FILL_RANDOM);
      send_frame(FRAME_UI_PROT, 4, FILL_RANDOM);
      send_frame(FRAME_OTHER, 3, FILL_RANDOM);
   endtask

   // Extreme octet values, and frames no longer than the three header octets.
   task automatic test_extremes_and_short();
      send_frame(FRAME_NOISE, 1, 8'h00);
      send_frame(FRAME_NOISE, 1, 8'hFF);
      send_frame(FRAME_UI_UNPROT, 2, 8'hFF);
      send_frame(FRAME_UI_UNPROT, 3, 8'h00);
   endtask

   // The smallest length: only the three header octets are covered.
   task automatic test_zero_length();
      settle_block();
      write_info_len(8'd0);
      send_frame(FRAME_UI_UNPROT, 5, 8'hFF);
   endtask

   // A write between octets of one frame: each octet is judged by the length
   // in force when it arrives. The block is settled before the write.
   task automatic test_mid_frame_write();
      settle_block();
      write_info_len(8'd2);
      send_octets(FRAME_UI_UNPROT, 7, 0, 4, FILL_RANDOM);
      settle_block();
      write_info_len(8'd0);
      send_octets(FRAME_UI_UNPROT, 7, 4, 3, FILL_RANDOM);
   endtask

   function automatic logic [BYTE_W-1:0] pick_info_len();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'($urandom_range(1, 8));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly well-formed UI frames with random content; the rest are other
   // frames, pure noise and very short frames. The length is changed now and
   // then with the block settled.
   task automatic test_random_frames(input int target);
      int             start;
      int             until_write;
      int             len;
      int             pick;
      frame_kind_type kind;
      start       = octets_sent;
      until_write = $urandom_range(5, 20);
      while (octets_sent - start < target) begin
         if (until_write == 0) begin
            settle_block();
            write_info_len(pick_info_len());
            until_write = $urandom_range(5, 20);
         end
         until_write--;
         pick = $urandom_range(0, 9);
         if (pick < 4) kind = FRAME_UI_UNPROT;
         else if (pick < 6) kind = FRAME_UI_PROT;
         else if (pick < 8) kind = FRAME_OTHER;
         else kind = FRAME_NOISE;
         if ($urandom_range(0, 15) == 0) len = $urandom_range(25, 300);
         else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 3);
         else len = $urandom_range(4, 24);
         if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
         send_frame(kind, len, FILL_RANDOM);
      end
      sender_steady = 1'b0;
   endtask

   // Frames longer than the saturating count, at the largest length and at zero.
   task automatic test_long_frames();
      settle_block();
      write_info_len(8'd255);
      send_frame(FRAME_UI_UNPROT, 600, FILL_RANDOM);
      settle_block();
      write_info_len(8'd0);
      send_frame(FRAME_UI_PROT, 530, FILL_RANDOM);
      send_frame(FRAME_UI_UNPROT, 520, FILL_RANDOM);
   endtask

   initial begin
      int waited;
      errors            = 0;
      frames_sent       = 0;
      octets_sent       = 0;
      fcs_checked       = 0;
      info_len_writes   = 0;
      sender_burst_left = 0;
      sender_steady     = 1'b0;
      info_len          = INFO_LEN_RESET;
      preset_frame();

      reset                       = 1'b1;
      req_ch.valid                = 1'b0;
      req_ch.data_byte            = '0;
      req_ch.last_byte            = 1'b0;
      csr_ch.valid                = 1'b0;
      csr_ch.unprotected_info_len = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_length();
      test_extremes_and_short();
      test_zero_length();
      test_mid_frame_write();
      test_random_frames(300);
      test_long_frames();

      // Drain: wait a bounded time for every owed value, then wait further so that any
      // stray result beat is still seen.
      req_ch.valid <= 1'b0;
      waited = 0;
      while (fcs_owed_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (fcs_owed_q.size() != 0) begin
         $error("%0d check values never arrived", fcs_owed_q.size());
         errors++;
      end

      $display("Covered %0d frames (%0d octets) and checked %0d check values,",
               frames_sent, octets_sent, fcs_checked);
      $display("across %0d register writes including lengths 0 and 255 and a mid-frame write.",
               info_len_writes);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lfc24_pkg.sv
hdl/lfc24_intf.sv
hdl/lfc24_fcs_engine.sv
hdl/llc_fcs_crc24.sv
dv/llc_fcs_crc24_test.sv
